### rtl/core/pcm_pkg.sv
// ---------------------------------------------------------------------------
// pcm_pkg
// Shared types and constants for the pixel color match classifier.
// ---------------------------------------------------------------------------
package pcm_pkg;

    localparam int PIX_W      = 8;
    localparam int HUE_W      = 9;
    localparam int HALF_W     = 8;
    localparam int CLS_W      = 3;
    localparam int CFG_IDX_W  = 3;
    localparam int NUM_W      = 15;   // 60*(t+d)+d, at most 30855
    localparam int DEN_W      = 9;    // 2*d
    localparam int QUO_W      = 6;    // quotient 0..60
    localparam int DIV_BITS   = 2;    // quotient bits per divider stage
    localparam int DIV_STAGES = QUO_W / DIV_BITS;
    localparam int PIPE_STAGES = DIV_STAGES + 3;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_MATCH_MODE  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_REF_RED     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_REF_GREEN   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_REF_BLUE    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_TOLERANCE   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_COLOR_CLASS = 3'd5;

    // color classes
    localparam logic [CLS_W-1:0] CLS_RED    = 3'd0;
    localparam logic [CLS_W-1:0] CLS_ORANGE = 3'd1;
    localparam logic [CLS_W-1:0] CLS_YELLOW = 3'd2;
    localparam logic [CLS_W-1:0] CLS_GREEN  = 3'd3;
    localparam logic [CLS_W-1:0] CLS_BLUE   = 3'd4;
    localparam logic [CLS_W-1:0] CLS_PURPLE = 3'd5;

    // hue sector, by which channel holds the maximum
    localparam logic [1:0] SEC_R = 2'd0;
    localparam logic [1:0] SEC_G = 2'd1;
    localparam logic [1:0] SEC_B = 2'd2;

    // S <= 102 is S < 103
    localparam logic [PIX_W-1:0] S_KEEP_MIN = 8'd103;
    localparam logic [PIX_W-1:0] V_REJ_MAX  = 8'd25;

    // half-degree hue assembly from quotient q = floor((60t+61d)/(2d))
    localparam logic [HALF_W-1:0] HALF_RED_SPLIT = 8'd30;
    localparam logic [HALF_W-1:0] HALF_RED_WRAP  = 8'd150;
    localparam logic [HALF_W-1:0] HALF_OFS_G     = 8'd30;
    localparam logic [HALF_W-1:0] HALF_OFS_B     = 8'd90;

    // class ranges in degrees
    localparam logic [HUE_W-1:0] HUE_RED_HI    = 9'd30;
    localparam logic [HUE_W-1:0] HUE_RED_LO2   = 9'd331;
    localparam logic [HUE_W-1:0] HUE_RED_HI2   = 9'd360;
    localparam logic [HUE_W-1:0] HUE_ORANGE_LO = 9'd31;
    localparam logic [HUE_W-1:0] HUE_ORANGE_HI = 9'd50;
    localparam logic [HUE_W-1:0] HUE_YELLOW_LO = 9'd51;
    localparam logic [HUE_W-1:0] HUE_YELLOW_HI = 9'd70;
    localparam logic [HUE_W-1:0] HUE_GREEN_LO  = 9'd71;
    localparam logic [HUE_W-1:0] HUE_GREEN_HI  = 9'd160;
    localparam logic [HUE_W-1:0] HUE_BLUE_LO   = 9'd161;
    localparam logic [HUE_W-1:0] HUE_BLUE_HI   = 9'd262;
    localparam logic [HUE_W-1:0] HUE_PURPLE_LO = 9'd263;
    localparam logic [HUE_W-1:0] HUE_PURPLE_HI = 9'd330;

    typedef struct packed {
        logic             mode;
        logic [PIX_W-1:0] ref_red;
        logic [PIX_W-1:0] ref_green;
        logic [PIX_W-1:0] ref_blue;
        logic [PIX_W-1:0] tol;
        logic [CLS_W-1:0] cls;
    } t_cfg;

    typedef struct packed {
        logic             tol_hit;
        logic [PIX_W-1:0] vmax;
        logic [PIX_W-1:0] diff;
        logic [PIX_W:0]   tdiff;    // sector difference plus d, 0..2d
        logic [1:0]       sector;
    } t_front;

    typedef struct packed {
        logic             tol_hit;
        logic             reject;
        logic             d_zero;
        logic [1:0]       sector;
        logic [DEN_W-1:0] den;
        logic [NUM_W-1:0] rem;
        logic [QUO_W-1:0] quo;
    } t_div;

    typedef struct packed {
        logic             is_match;
        logic             low_sv_reject;
        logic [HUE_W-1:0] hue;
    } t_result;

endpackage

### rtl/core/pixel_color_match_classify.sv
// ---------------------------------------------------------------------------
// pixel_color_match_classify
// Classifies one RGB pixel per clock, unless stalled, against a reference
// color or a hue class.
// Input channel: i_valid / o_stall with i_pix_red, i_pix_green, i_pix_blue.
// A transfer happens on a rising edge with i_valid high and o_stall low.
// Output channel: o_valid / i_stall with o_is_match, o_low_sv_reject,
// o_hue_degrees. Configuration: i_cfg_valid / o_cfg_ready with i_cfg_index
// and i_cfg_data; o_cfg_ready is always high. Write registers only while
// the pipeline is empty.
// Depth: six register stages; a result shows on the outputs once it has passed
// through all six and transfers out while i_stall is low. Throughput: one
// pixel per cycle while the output is not stalled; the three-stage
// hue divider (two quotient bits per stage) sets the depth.
// Reset (synchronous, active low) clears the configuration registers and the
// stage valid bits, which empties the pipeline. When the receiver stalls, the
// output holds and upstream stages keep filling any empty slots; o_stall
// rises only once every stage is full.
// ---------------------------------------------------------------------------
module pixel_color_match_classify
    import pcm_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_stall,
    input  logic [PIX_W-1:0]     i_pix_red,
    input  logic [PIX_W-1:0]     i_pix_green,
    input  logic [PIX_W-1:0]     i_pix_blue,
    output logic                 o_valid,
    input  logic                 i_stall,
    output logic                 o_is_match,
    output logic                 o_low_sv_reject,
    output logic [HUE_W-1:0]     o_hue_degrees,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [PIX_W-1:0]     i_cfg_data
);

    t_cfg                   r_cfg;
    logic [PIPE_STAGES-1:0] r_vld, n_vld;
    logic [PIPE_STAGES-1:0] rdy;
    t_div                   div_pipe [DIV_STAGES+1];
    t_result                res;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_MATCH_MODE:  r_cfg.mode      <= i_cfg_data[0];
                CFG_REF_RED:     r_cfg.ref_red   <= i_cfg_data;
                CFG_REF_GREEN:   r_cfg.ref_green <= i_cfg_data;
                CFG_REF_BLUE:    r_cfg.ref_blue  <= i_cfg_data;
                CFG_TOLERANCE:   r_cfg.tol       <= i_cfg_data;
                CFG_COLOR_CLASS: r_cfg.cls       <= i_cfg_data[CLS_W-1:0];
                default: ;
            endcase
        end
    end

    // a stage loads when it is empty or its successor loads
    always_comb begin
        rdy[PIPE_STAGES-1] = !r_vld[PIPE_STAGES-1] || !i_stall;
        for (int k = PIPE_STAGES - 2; k >= 0; k--) begin
            rdy[k] = !r_vld[k] || rdy[k+1];
        end
        n_vld = r_vld;
        if (rdy[0]) n_vld[0] = i_valid;
        for (int k = 1; k < PIPE_STAGES; k++) begin
            if (rdy[k]) n_vld[k] = r_vld[k-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= n_vld;
        end
    end

    pcm_front u_front (
        .i_clk       (i_clk),
        .i_ld1       (rdy[0]),
        .i_ld2       (rdy[1]),
        .i_cfg       (r_cfg),
        .i_pix_red   (i_pix_red),
        .i_pix_green (i_pix_green),
        .i_pix_blue  (i_pix_blue),
        .o_div       (div_pipe[0])
    );

    for (genvar g = 0; g < DIV_STAGES; g++) begin : g_div
        pcm_div_step u_div_step (
            .i_clk (i_clk),
            .i_ld  (rdy[g+2]),
            .i_div (div_pipe[g]),
            .o_div (div_pipe[g+1])
        );
    end

    pcm_classify u_classify (
        .i_clk (i_clk),
        .i_ld  (rdy[PIPE_STAGES-1]),
        .i_cfg (r_cfg),
        .i_div (div_pipe[DIV_STAGES]),
        .o_res (res)
    );

    assign o_stall         = !rdy[0];
    assign o_valid         = r_vld[PIPE_STAGES-1];
    assign o_is_match      = res.is_match;
    assign o_low_sv_reject = res.low_sv_reject;
    assign o_hue_degrees   = res.hue;

endmodule

### rtl/core/pcm_front.sv
// ---------------------------------------------------------------------------
// pcm_front
// Stage 1: min/max, sector and tolerance test. Stage 2: divider numerator
// and low saturation / value rejection.
// ---------------------------------------------------------------------------
module pcm_front
    import pcm_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_ld1,
    input  logic             i_ld2,
    input  t_cfg             i_cfg,
    input  logic [PIX_W-1:0] i_pix_red,
    input  logic [PIX_W-1:0] i_pix_green,
    input  logic [PIX_W-1:0] i_pix_blue,
    output t_div             o_div
);

    function automatic logic [PIX_W-1:0] abs_diff(input logic [PIX_W-1:0] a,
                                                  input logic [PIX_W-1:0] b);
        return (a > b) ? (a - b) : (b - a);
    endfunction

    t_front           n_front, r_front;
    t_div             n_div, r_div;
    logic [PIX_W-1:0] vmin;
    logic [PIX_W-1:0] vmax;
    logic [PIX_W-1:0] diff;
    logic [16:0]      s_lhs;
    logic [16:0]      s_rhs;

    always_comb begin
        vmax = i_pix_red;
        if (i_pix_green > vmax) vmax = i_pix_green;
        if (i_pix_blue > vmax) vmax = i_pix_blue;
        vmin = i_pix_red;
        if (i_pix_green < vmin) vmin = i_pix_green;
        if (i_pix_blue < vmin) vmin = i_pix_blue;
        diff = vmax - vmin;

        n_front.vmax = vmax;
        n_front.diff = diff;
        // t + d stays in 0..2d, so 9-bit wraparound is harmless
        if (vmax == i_pix_red) begin
            n_front.sector = SEC_R;
            n_front.tdiff  = {1'b0, i_pix_green} + {1'b0, diff} - {1'b0, i_pix_blue};
        end else if (vmax == i_pix_green) begin
            n_front.sector = SEC_G;
            n_front.tdiff  = {1'b0, i_pix_blue} + {1'b0, diff} - {1'b0, i_pix_red};
        end else begin
            n_front.sector = SEC_B;
            n_front.tdiff  = {1'b0, i_pix_red} + {1'b0, diff} - {1'b0, i_pix_green};
        end
        n_front.tol_hit = (abs_diff(i_pix_red, i_cfg.ref_red) <= i_cfg.tol) &&
                          (abs_diff(i_pix_green, i_cfg.ref_green) <= i_cfg.tol) &&
                          (abs_diff(i_pix_blue, i_cfg.ref_blue) <= i_cfg.tol);
    end

    always_ff @(posedge i_clk) begin
        if (i_ld1) begin
            r_front <= n_front;
        end
    end

    always_comb begin
        // S <= 102  <=>  255*d + v/2 < 103*v
        s_lhs = {1'b0, r_front.diff, 8'b0} - {9'b0, r_front.diff}
              + {10'b0, r_front.vmax[PIX_W-1:1]};
        s_rhs = {9'b0, r_front.vmax} * {9'b0, S_KEEP_MIN};

        n_div.tol_hit = r_front.tol_hit;
        n_div.reject  = (s_lhs < s_rhs) || (r_front.vmax <= V_REJ_MAX);
        n_div.d_zero  = (r_front.diff == '0);
        n_div.sector  = r_front.sector;
        n_div.den     = {r_front.diff, 1'b0};
        // 60*(t+d) + d
        n_div.rem     = {r_front.tdiff, 6'b0} - {4'b0, r_front.tdiff, 2'b0}
                      + {7'b0, r_front.diff};
        n_div.quo     = '0;
    end

    always_ff @(posedge i_clk) begin
        if (i_ld2) begin
            r_div <= n_div;
        end
    end

    assign o_div = r_div;

endmodule

### rtl/core/pcm_div_step.sv
// ---------------------------------------------------------------------------
// pcm_div_step
// One registered stage of the restoring hue divider, DIV_BITS quotient bits.
// ---------------------------------------------------------------------------
module pcm_div_step
    import pcm_pkg::*;
(
    input  logic i_clk,
    input  logic i_ld,
    input  t_div i_div,
    output t_div o_div
);

    t_div             n_div, r_div;
    logic [NUM_W-1:0] rem;
    logic [NUM_W-1:0] den_top;
    logic [QUO_W-1:0] quo;

    // remainder is kept below 2*den_top and doubled after every step
    always_comb begin
        den_top = NUM_W'({i_div.den, {(QUO_W-1){1'b0}}});
        rem     = i_div.rem;
        quo     = i_div.quo;
        for (int k = 0; k < DIV_BITS; k++) begin
            if (rem >= den_top) begin
                rem = rem - den_top;
                quo = {quo[QUO_W-2:0], 1'b1};
            end else begin
                quo = {quo[QUO_W-2:0], 1'b0};
            end
            rem = {rem[NUM_W-2:0], 1'b0};
        end
        n_div     = i_div;
        n_div.rem = rem;
        n_div.quo = quo;
    end

    always_ff @(posedge i_clk) begin
        if (i_ld) begin
            r_div <= n_div;
        end
    end

    assign o_div = r_div;

endmodule

### rtl/core/pcm_classify.sv
// ---------------------------------------------------------------------------
// pcm_classify
// Final stage: hue assembly from the quotient, class range test, result mux.
// ---------------------------------------------------------------------------
module pcm_classify
    import pcm_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_ld,
    input  t_cfg    i_cfg,
    input  t_div    i_div,
    output t_result o_res
);

    t_result           n_res, r_res;
    logic [HALF_W-1:0] q;
    logic [HALF_W-1:0] half;
    logic [HUE_W-1:0]  hue;
    logic              hit;

    always_comb begin
        q = {{(HALF_W-QUO_W){1'b0}}, i_div.quo};
        case (i_div.sector)
            SEC_R:   half = (q >= HALF_RED_SPLIT) ? (q - HALF_RED_SPLIT)
                                                  : (q + HALF_RED_WRAP);
            SEC_G:   half = q + HALF_OFS_G;
            default: half = q + HALF_OFS_B;
        endcase
        if (i_div.d_zero) half = '0;   // gray pixel
        hue = {half, 1'b0};

        case (i_cfg.cls)
            CLS_RED:    hit = (hue <= HUE_RED_HI) ||
                              ((hue >= HUE_RED_LO2) && (hue <= HUE_RED_HI2));
            CLS_ORANGE: hit = (hue >= HUE_ORANGE_LO) && (hue <= HUE_ORANGE_HI);
            CLS_YELLOW: hit = (hue >= HUE_YELLOW_LO) && (hue <= HUE_YELLOW_HI);
            CLS_GREEN:  hit = (hue >= HUE_GREEN_LO) && (hue <= HUE_GREEN_HI);
            CLS_BLUE:   hit = (hue >= HUE_BLUE_LO) && (hue <= HUE_BLUE_HI);
            CLS_PURPLE: hit = (hue >= HUE_PURPLE_LO) && (hue <= HUE_PURPLE_HI);
            default:    hit = 1'b0;
        endcase

        if (i_cfg.mode) begin
            n_res.is_match      = !i_div.reject && hit;
            n_res.low_sv_reject = i_div.reject;
            n_res.hue           = hue;
        end else begin
            n_res.is_match      = i_div.tol_hit;
            n_res.low_sv_reject = 1'b0;
            n_res.hue           = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ld) begin
            r_res <= n_res;
        end
    end

    assign o_res = r_res;

endmodule
